// File: rtl/assert_macros.svh
// Assertion macros used by the queue of the Gaussian sample scaler
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the antecedent
`define PGS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition must hold in the cycle after the antecedent
`define PGS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/pgs_pkg.sv
// Shared types and constants of the polar Gaussian sample scaler
`default_nettype none
package pgs_pkg;

   localparam int QDEPTH     = 4;
   localparam int QPTR_W     = $clog2(QDEPTH);
   localparam int LOG_STEPS  = 24;
   localparam int DIV_STEPS  = 30;
   localparam int SQRT_STEPS = 15;

   localparam logic [31:0] RR_ONE  = 32'h4000_0000;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   typedef enum logic [1:0] {
      MODE_RAW   = 2'd0,
      MODE_SCALE = 2'd1,
      MODE_CLAMP = 2'd2,
      MODE_SPARE = 2'd3
   } pgs_mode_type;

   typedef enum logic [1:0] {
      REG_MODE = 2'd0,
      REG_LOW  = 2'd1,
      REG_HIGH = 2'd2,
      REG_GAIN = 2'd3
   } pgs_reg_type;

   // Accepted pair as queued for the back end
   typedef struct packed {
      logic        xneg;
      logic [30:0] x2;
      logic [30:0] rr;
   } pgs_item_type;

   typedef struct packed {
      logic        xneg;
      logic [30:0] x2;
      logic [30:0] rr;
      logic [28:0] lq;
   } pgs_log_type;

   typedef struct packed {
      logic        xneg;
      logic [14:0] gmag;
   } pgs_root_type;

endpackage
`default_nettype wire

// File: rtl/pgs_front.sv
// Input stage: registers a pair, forms the radius and drops rejected pairs
`default_nettype none
module pgs_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // uniform_x [15:0], uniform_y [31:16]
   input  logic                  q_full,
   output logic                  push,
   output pgs_pkg::pgs_item_type push_item
);
   import pgs_pkg::*;

   logic               fvalid_ff;
   logic signed [15:0] x_ff;
   logic signed [15:0] y_ff;
   logic signed [31:0] xsq;
   logic signed [31:0] ysq;
   logic [31:0]        rr;
   logic               accept;
   logic               fadv;

   assign xsq    = x_ff * x_ff;
   assign ysq    = y_ff * y_ff;
   assign rr     = {1'b0, xsq[30:0]} + {1'b0, ysq[30:0]};
   assign accept = (rr != 32'd0) && (rr <= RR_ONE);

   assign push           = fvalid_ff && accept && !q_full;
   assign fadv           = !fvalid_ff || !accept || !q_full;
   assign req_tready     = fadv;
   assign push_item.xneg = x_ff[15];
   assign push_item.x2   = xsq[30:0];
   assign push_item.rr   = rr[30:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fvalid_ff <= 1'b0;
      end else if (fadv) begin
         fvalid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (fadv) begin
         x_ff <= req_tdata[15:0];
         y_ff <= req_tdata[31:16];
      end
   end

endmodule
`default_nettype wire

// File: rtl/pgs_queue.sv
// Short queue between the front end and the arithmetic back end
`default_nettype none
`include "assert_macros.svh"
module pgs_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  pgs_pkg::pgs_item_type push_item,
   input  logic                  pop,
   output logic                  q_valid,
   output pgs_pkg::pgs_item_type q_item,
   output logic                  q_full
);
   import pgs_pkg::*;

   pgs_item_type      mem [0:QDEPTH-1];
   logic [QPTR_W-1:0] wptr_ff;
   logic [QPTR_W-1:0] rptr_ff;
   logic [QPTR_W:0]   count_ff;
   logic [QPTR_W:0]   count_in;

   assign q_valid = count_ff != '0;
   assign q_full  = count_ff == (QPTR_W + 1)'(QDEPTH);
   assign q_item  = mem[rptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (pop) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wptr_ff] <= push_item;
      end
   end

   `PGS_ASSERT_IMPLY(a_no_overfill, clock, reset, 1'b1, count_ff <= (QPTR_W + 1)'(QDEPTH), "queue overfilled")
   `PGS_ASSERT_IMPLY(a_push_room, clock, reset, push, !q_full, "push into full queue")
   `PGS_ASSERT_IMPLY(a_pop_data, clock, reset, pop, count_ff != '0, "pop from empty queue")
   `PGS_ASSERT_NEXT(a_fill_step, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "fill count lost a push")

endmodule
`default_nettype wire

// File: rtl/pgs_log.sv
// Logarithm pipeline: normalise the radius, square out 24 bits of -log2, scale to -ln
`default_nettype none
module pgs_log (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  pgs_pkg::pgs_item_type in_item,
   output logic                  out_valid,
   output pgs_pkg::pgs_log_type  out_data
);
   import pgs_pkg::*;

   typedef struct packed {
      pgs_item_type         item;
      logic [4:0]           shift;
      logic [30:0]          mant;
      logic [LOG_STEPS-1:0] frac;
   } sq_stage_type;

   logic         a_valid_ff;
   pgs_item_type a_item_ff;
   logic [4:0]   a_shift_ff;
   logic [4:0]   top_in;

   logic         sq_valid_ff [0:LOG_STEPS];
   sq_stage_type sq_ff       [0:LOG_STEPS];

   logic         nl_valid_ff;
   pgs_item_type nl_item_ff;
   logic [28:0]  nl_ff;
   logic [28:0]  nl_in;
   logic [60:0]  lq_prod;

   // Index of the top set bit of the radius
   always_comb begin
      top_in = 5'd0;
      for (int i = 0; i < 31; i++) begin
         if (in_item.rr[i]) begin
            top_in = 5'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff     <= 1'b0;
         sq_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         a_valid_ff     <= in_valid;
         sq_valid_ff[0] <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_item_ff        <= in_item;
         a_shift_ff       <= 5'd30 - top_in;
         sq_ff[0].item    <= a_item_ff;
         sq_ff[0].shift   <= a_shift_ff;
         sq_ff[0].mant    <= a_item_ff.rr << a_shift_ff;
         sq_ff[0].frac    <= '0;
      end
   end

   for (genvar k = 0; k < LOG_STEPS; k++) begin : g_square
      logic [61:0]  sq;
      sq_stage_type nxt_in;

      always_comb begin
         sq          = 62'(sq_ff[k].mant) * 62'(sq_ff[k].mant);
         nxt_in      = sq_ff[k];
         nxt_in.mant = sq[61] ? sq[61:31] : sq[60:30];
         nxt_in.frac = {sq_ff[k].frac[LOG_STEPS-2:0], sq[61]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sq_valid_ff[k+1] <= sq_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_ff[k+1] <= nxt_in;
         end
      end
   end

   assign nl_in   = {sq_ff[LOG_STEPS].shift, {LOG_STEPS{1'b0}}}
                    - {5'd0, sq_ff[LOG_STEPS].frac};
   assign lq_prod = 61'(nl_ff) * 61'(LN2_Q32);

   always_ff @(posedge clock) begin
      if (reset) begin
         nl_valid_ff <= 1'b0;
         out_valid   <= 1'b0;
      end else if (adv) begin
         nl_valid_ff <= sq_valid_ff[LOG_STEPS];
         out_valid   <= nl_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nl_item_ff    <= sq_ff[LOG_STEPS].item;
         nl_ff         <= nl_in;
         out_data.xneg <= nl_item_ff.xneg;
         out_data.x2   <= nl_item_ff.x2;
         out_data.rr   <= nl_item_ff.rr;
         out_data.lq   <= lq_prod[60:32];
      end
   end

endmodule
`default_nettype wire

// File: rtl/pgs_root.sv
// Magnitude pipeline: 2*x^2*L, one-bit-a-stage divide by r, one-bit-a-stage square root
`default_nettype none
module pgs_root (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  pgs_pkg::pgs_log_type  in_data,
   output logic                  out_valid,
   output pgs_pkg::pgs_root_type out_data
);
   import pgs_pkg::*;

   typedef struct packed {
      logic                 xneg;
      logic [30:0]          rr;
      logic [30:0]          rem;
      logic [DIV_STEPS-1:0] low;
      logic [DIV_STEPS-1:0] quo;
   } div_stage_type;

   typedef struct packed {
      logic                  xneg;
      logic [DIV_STEPS-1:0]  val;
      logic [SQRT_STEPS-1:0] root;
   } sqrt_stage_type;

   logic [60:0]    num_in;
   logic           dv_valid_ff [0:DIV_STEPS];
   div_stage_type  dv_ff       [0:DIV_STEPS];
   logic           rt_valid_ff [0:SQRT_STEPS];
   sqrt_stage_type rt_ff       [0:SQRT_STEPS];

   assign num_in = (61'(in_data.x2) * 61'(in_data.lq)) << 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ff[0].xneg <= in_data.xneg;
         dv_ff[0].rr   <= in_data.rr;
         dv_ff[0].rem  <= num_in[60:30];
         dv_ff[0].low  <= num_in[29:0];
         dv_ff[0].quo  <= '0;
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_divide
      logic [31:0]   trial;
      logic [31:0]   diff;
      logic          ge;
      div_stage_type nxt_in;

      always_comb begin
         trial      = {dv_ff[j].rem, dv_ff[j].low[DIV_STEPS-1-j]};
         diff       = trial - {1'b0, dv_ff[j].rr};
         ge         = trial >= {1'b0, dv_ff[j].rr};
         nxt_in     = dv_ff[j];
         nxt_in.rem = ge ? diff[30:0] : trial[30:0];
         nxt_in.quo = {dv_ff[j].quo[DIV_STEPS-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j+1] <= 1'b0;
         end else if (adv) begin
            dv_valid_ff[j+1] <= dv_valid_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_ff[j+1] <= nxt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rt_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         rt_valid_ff[0] <= dv_valid_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rt_ff[0].xneg <= dv_ff[DIV_STEPS].xneg;
         rt_ff[0].val  <= dv_ff[DIV_STEPS].quo;
         rt_ff[0].root <= '0;
      end
   end

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
      logic [SQRT_STEPS-1:0] cand;
      logic [DIV_STEPS-1:0]  csq;
      sqrt_stage_type        nxt_in;

      always_comb begin
         cand   = rt_ff[i].root | (SQRT_STEPS'(1) << (SQRT_STEPS - 1 - i));
         csq    = DIV_STEPS'(cand) * DIV_STEPS'(cand);
         nxt_in = rt_ff[i];
         if (csq <= rt_ff[i].val) begin
            nxt_in.root = cand;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rt_valid_ff[i+1] <= 1'b0;
         end else if (adv) begin
            rt_valid_ff[i+1] <= rt_valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rt_ff[i+1] <= nxt_in;
         end
      end
   end

   assign out_valid     = rt_valid_ff[SQRT_STEPS];
   assign out_data.xneg = rt_ff[SQRT_STEPS].xneg;
   assign out_data.gmag = rt_ff[SQRT_STEPS].root;

endmodule
`default_nettype wire

// File: rtl/pgs_scale.sv
// Scale, offset, clamp and saturate; holds the result register and drives the pipe enable
`default_nettype none
module pgs_scale (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  pgs_pkg::pgs_root_type in_data,
   input  pgs_pkg::pgs_mode_type output_mode,
   input  logic signed [31:0]    range_low,
   input  logic signed [31:0]    range_high,
   input  logic [15:0]           spread_gain,
   output logic                  adv,
   input  logic                  out_ready,
   output logic                  out_valid,
   output logic [47:0]           out_data      // normal_value [15:0], scaled_value [47:16]
);
   import pgs_pkg::*;

   logic signed [32:0] width;
   logic [32:0]        wmag;
   logic signed [32:0] msum;
   logic signed [32:0] mid;

   logic               s1_valid_ff;
   logic               s1_xneg_ff;
   logic               s1_neg_ff;
   logic [14:0]        s1_gmag_ff;
   logic [47:0]        s1_prod_ff;

   logic               s2_valid_ff;
   logic               s2_xneg_ff;
   logic               s2_neg_ff;
   logic [14:0]        s2_gmag_ff;
   logic [39:0]        s2_prod_ff;
   logic [63:0]        p2;

   logic signed [41:0] signed_prod;
   logic signed [41:0] total;
   logic signed [41:0] bounded;
   logic [31:0]        scaled_in;
   logic [15:0]        normal_in;

   logic               out_valid_ff;
   logic [47:0]        out_data_ff;

   assign adv   = !out_valid_ff || out_ready;
   assign width = {range_high[31], range_high} - {range_low[31], range_low};
   assign wmag  = width[32] ? 33'(-width) : 33'(width);
   assign msum  = {range_low[31], range_low} + {range_high[31], range_high};
   // Halve toward zero
   assign mid   = (msum + $signed({32'd0, msum[32]})) >>> 1;
   assign p2    = 64'(s1_prod_ff) * 64'(spread_gain);

   always_comb begin
      signed_prod = s2_neg_ff ? -$signed({2'b00, s2_prod_ff}) : $signed({2'b00, s2_prod_ff});
      total       = signed_prod + 42'(mid);
      bounded     = total;
      if (output_mode == MODE_CLAMP) begin
         priority if (total < 42'(range_low)) begin
            bounded = 42'(range_low);
         end else if (total > 42'(range_high)) begin
            bounded = 42'(range_high);
         end else begin
            bounded = total;
         end
      end
      priority if (output_mode == MODE_RAW) begin
         scaled_in = 32'd0;
      end else if (bounded > 42'sd2147483647) begin
         scaled_in = 32'h7FFF_FFFF;
      end else if (bounded < -42'sd2147483648) begin
         scaled_in = 32'h8000_0000;
      end else begin
         scaled_in = bounded[31:0];
      end
      normal_in = s2_xneg_ff ? -{1'b0, s2_gmag_ff} : {1'b0, s2_gmag_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= in_valid;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_xneg_ff  <= in_data.xneg;
         s1_neg_ff   <= (in_data.xneg && (in_data.gmag != 15'd0)) != width[32];
         s1_gmag_ff  <= in_data.gmag;
         s1_prod_ff  <= 48'(in_data.gmag) * 48'(wmag);
         s2_xneg_ff  <= s1_xneg_ff;
         s2_neg_ff   <= s1_neg_ff;
         s2_gmag_ff  <= s1_gmag_ff;
         s2_prod_ff  <= p2[63:24];
         out_data_ff <= {scaled_in, normal_in};
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule
`default_nettype wire

// File: rtl/polar_gaussian_sample_scaler.sv
// Polar-method Gaussian sample scaler: one uniform pair in, zero or one normal sample out.
// Takes one pair of uniform samples per clock while the queue has room; a pair whose radius is
// zero or beyond one is dropped in the input stage and gives no item, any other pair gives one
// item with the normal sample in Q4.12 and its scaled, offset (and in mode 2 clamped) Q16.16
// value, zero in mode 0. Sustained rate is one pair per cycle while the result port is ready;
// the pipeline holds the 24-stage log squaring chain, the 30-stage divider and the 15-stage
// square root. A four-entry queue behind the input stage lets the input flow until it fills
// while the result port stalls. Write the registers only while no item is in flight.
`default_nettype none
module polar_gaussian_sample_scaler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,     // uniform_x [15:0], uniform_y [31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,     // normal_value [15:0], scaled_value [47:16]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import pgs_pkg::*;

   pgs_mode_type       mode_ff;
   logic signed [31:0] low_ff;
   logic signed [31:0] high_ff;
   logic [15:0]        gain_ff;
   pgs_reg_type        csr_sel;
   logic               csr_wr;

   logic               push;
   pgs_item_type       push_item;
   logic               q_valid;
   pgs_item_type       q_item;
   logic               q_full;
   logic               adv;
   logic               pop;
   logic               log_valid;
   pgs_log_type        log_data;
   logic               root_valid;
   pgs_root_type       root_data;

   assign csr_pready = 1'b1;
   assign csr_sel    = pgs_reg_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RAW;
         low_ff  <= -32'sd65536;
         high_ff <= 32'sd65536;
         gain_ff <= 16'd4096;
      end else if (csr_wr) begin
         unique case (csr_sel)
            REG_MODE: mode_ff <= pgs_mode_type'(csr_pwdata[1:0]);
            REG_LOW:  low_ff  <= csr_pwdata;
            REG_HIGH: high_ff <= csr_pwdata;
            REG_GAIN: gain_ff <= csr_pwdata[15:0];
            default:  mode_ff <= mode_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_MODE: csr_prdata = {30'd0, mode_ff};
         REG_LOW:  csr_prdata = low_ff;
         REG_HIGH: csr_prdata = high_ff;
         REG_GAIN: csr_prdata = {16'd0, gain_ff};
         default:  csr_prdata = 32'd0;
      endcase
   end

   assign pop = adv && q_valid;

   pgs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .push       (push),
      .push_item  (push_item)
   );

   pgs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_full    (q_full)
   );

   pgs_log u_log (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (q_valid),
      .in_item   (q_item),
      .out_valid (log_valid),
      .out_data  (log_data)
   );

   pgs_root u_root (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (log_valid),
      .in_data   (log_data),
      .out_valid (root_valid),
      .out_data  (root_data)
   );

   pgs_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (root_valid),
      .in_data     (root_data),
      .output_mode (mode_ff),
      .range_low   (low_ff),
      .range_high  (high_ff),
      .spread_gain (gain_ff),
      .adv         (adv),
      .out_ready   (rsp_tready),
      .out_valid   (rsp_tvalid),
      .out_data    (rsp_tdata)
   );

endmodule
`default_nettype wire
